>>> hw/rtl/sts_pkg.sv
// Shared types and constants for the sorted table search block.
// Holds the operation codes, the controller states and the transaction structs.
// No dependencies.
`default_nettype none

package sts_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 6;

    // Operation codes carried in an input transaction. Code 3 has no meaning.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } sts_op_t;

    // Values of the search_mode register.
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_BPROBE,
        ST_BCMP,
        ST_DONE
    } sts_state_t;

    typedef struct packed {
        sts_op_t                    operation;
        logic signed [VALUE_W-1:0]  value;
    } sts_in_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic               in_order;
        logic               full_error;
    } sts_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/sts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Parameterized by word width and depth. No package dependency.
`default_nettype none

module sts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_table_search.sv
// Top level of the sorted table search block: controller, state registers, output register.
// Depends on sts_pkg and on sts_ram, which holds the element table.
//
//   Channel   Ports                          Direction  Carries
//   --------  -----------------------------  ---------  ------------------------------
//   input     s_valid, s_ready, s_data       in         operation and value (sts_in_t)
//   result    m_valid, m_ready, m_data       out        found, position, in_order,
//                                                       full_error (sts_out_t)
//   config    cfg_valid, cfg_ready,          in         search_mode (1 bit)
//             cfg_search_mode
//
// A clear, an append or an unused code goes from IDLE straight to DONE, which loads the output
// register; a linear search issues one pipelined read of the single RAM port per cycle, and a
// binary search a read and a compare per halving step. One transaction is worked on at a time.
// Reset: synchronous, active low; the element RAM is never cleared, only entries below count
// are read. Stalls: a result held in the output register makes the next result wait in DONE.
`default_nettype none

module sorted_table_search #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input transactions.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sts_pkg::sts_in_t  s_data,
    // Result transactions.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sts_pkg::sts_out_t      m_data,
    // Configuration write channel.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_search_mode
);

    import sts_pkg::*;

    // AW indexes the table; CW also holds the count of a full table.
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // Controller state and architectural state.
    sts_state_t                 state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       order_reg, order_next;
    logic signed [VALUE_W-1:0]  prev_reg, prev_next;
    logic                       mode_reg, mode_next;

    // Search working registers.
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]              scan_idx_reg, scan_idx_next;
    logic [CW-1:0]              last_addr_reg, last_addr_next;
    logic                       pend_reg, pend_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hix_reg, hix_next;
    logic [CW-1:0]              mid_reg, mid_next;

    // Pending result and the output register.
    sts_out_t                   res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    sts_out_t                   m_data_reg, m_data_next;

    // RAM interface.
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [VALUE_W-1:0]         ram_rd_data;
    logic signed [VALUE_W-1:0]  probe;

    // Helpers for the halving search and for the position field.
    logic [CW:0]                mid_sum;
    logic [CW-1:0]              mid_calc;
    logic [CW-1:0]              hit_idx;
    logic [CW+POS_W-1:0]        hit_wide;
    logic [POS_W-1:0]           hit_pos;
    logic                       s_fire;
    logic                       out_free;
    logic                       scan_issue;

    sts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_data.value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign probe = $signed(ram_rd_data);

    // The midpoint rounds down; lo < hix whenever it is used, so the sum never goes negative.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hix_reg} - (CW + 1)'(1);
    assign mid_calc = mid_sum[CW:1];

    // An index wider than the position field is reported masked to its low bits.
    assign hit_wide = {{POS_W{1'b0}}, hit_idx};
    assign hit_pos  = hit_wide[POS_W-1:0];

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_issue = (scan_idx_reg < count_reg);
    assign cfg_ready  = 1'b1;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            order_reg   <= 1'b1;
            mode_reg    <= MODE_BINARY;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            order_reg   <= order_next;
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers carry no reset: none is read before it is written.
    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        key_reg       <= key_next;
        scan_idx_reg  <= scan_idx_next;
        last_addr_reg <= last_addr_next;
        lo_reg        <= lo_next;
        hix_reg       <= hix_next;
        mid_reg       <= mid_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        order_next     = order_reg;
        prev_next      = prev_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        scan_idx_next  = scan_idx_reg;
        last_addr_next = last_addr_reg;
        pend_next      = pend_reg;
        lo_next        = lo_reg;
        hix_next       = hix_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[AW-1:0];
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_idx_reg[AW-1:0];
        hit_idx        = last_addr_reg;

        if (cfg_valid && cfg_ready) begin
            mode_next = cfg_search_mode;
        end

        // The output register drains independently of the controller.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_next.found      = 1'b0;
                    res_next.position   = '0;
                    res_next.in_order   = order_reg;
                    res_next.full_error = 1'b0;
                    key_next            = s_data.value;
                    state_next          = ST_DONE;
                    case (s_data.operation)
                        OP_CLEAR: begin
                            count_next        = '0;
                            order_next        = 1'b1;
                            res_next.in_order = 1'b1;
                        end
                        OP_APPEND: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_next.full_error = 1'b1;
                            end else begin
                                ram_wr_en  = 1'b1;
                                prev_next  = s_data.value;
                                count_next = count_reg + CW'(1);
                                if ((count_reg != '0) && (prev_reg > s_data.value)) begin
                                    order_next = 1'b0;
                                end
                                res_next.in_order = order_next;
                            end
                        end
                        OP_SEARCH: begin
                            // The appended element is already written when the first read
                            // of a search is issued, so no forwarding is needed.
                            if (mode_reg == MODE_LINEAR) begin
                                scan_idx_next = '0;
                                pend_next     = 1'b0;
                                state_next    = ST_LSCAN;
                            end else begin
                                lo_next    = '0;
                                hix_next   = count_reg;
                                state_next = ST_BPROBE;
                            end
                        end
                        default: begin
                            // The unused code changes nothing and reports the order flag.
                        end
                    endcase
                end
            end

            ST_LSCAN: begin
                // One read issued per cycle; the data of the previous read is compared.
                hit_idx = last_addr_reg;
                if (pend_reg && (probe == key_reg)) begin
                    res_next.found    = 1'b1;
                    res_next.position = hit_pos;
                    pend_next         = 1'b0;
                    state_next        = ST_DONE;
                end else if (!scan_issue) begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = scan_idx_reg[AW-1:0];
                    last_addr_next = scan_idx_reg;
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    pend_next      = 1'b1;
                end
            end

            ST_BPROBE: begin
                if (lo_reg >= hix_reg) begin
                    state_next = ST_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_calc[AW-1:0];
                    mid_next    = mid_calc;
                    state_next  = ST_BCMP;
                end
            end

            ST_BCMP: begin
                hit_idx = mid_reg;
                if (probe == key_reg) begin
                    res_next.found    = 1'b1;
                    res_next.position = hit_pos;
                    state_next        = ST_DONE;
                end else if (probe > key_reg) begin
                    hix_next   = mid_reg;
                    state_next = ST_BPROBE;
                end else begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = ST_BPROBE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/sts_checker.sv
// Port-level checker for sorted_table_search, attached to it by the bind below.
// Depends on sts_pkg and on the top level's port names.
`default_nettype none

module sts_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire sts_pkg::sts_out_t m_data
);

    import sts_pkg::*;

    // After reset no result is presented.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // One transaction at a time: the block is busy in the cycle after an acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A dropped append never reports a search hit or a position.
    a_full_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_error |-> !m_data.found && (m_data.position == '0))
        else $error("full_error together with a search result");

    // A position is reported only with a hit.
    a_pos_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> (m_data.position == '0))
        else $error("nonzero position without a hit");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind sorted_table_search sts_checker u_sts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> tb/tb_sorted_table_search.sv
// Self-checking testbench for sorted_table_search: directed table, then random phases.
// Depends on sts_pkg and on the sorted_table_search RTL; a built-in predictor of the
// table state supplies the expected result of every input transaction.

module tb_sorted_table_search;

    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int unsigned TABLE_DEPTH = 64;

    // Operation code 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int VALUE_MAX = 32'h7fff_ffff;
    localparam int VALUE_MIN = 32'h8000_0000;

    localparam int RESET_CYCLES = 5;
    localparam int TOTAL_ITEMS  = 1700;  // Stimulus stops once this many real operations went in.
    localparam int QUIET_AFTER  = 1500;  // From here on neither side idles.
    localparam int HOLD_PHASE   = 15;    // Random phase during which the receiver holds off.
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 100;   // Longer than the slowest linear search.
    localparam int STALL_LIMIT  = 3000;  // Cycles without any transaction before giving up.
    localparam int MAX_REPORTS  = 40;

    // How the values of one random phase are spread.
    typedef enum int {
        SPREAD_NARROW,
        SPREAD_MID,
        SPREAD_FULL,
        SPREAD_EDGES
    } value_spread_t;

    // One row of the directed table. A row either writes the mode register or sends one
    // input transaction, optionally with the result typed in by hand.
    typedef struct {
        bit       is_mode_write;
        logic     mode_value;
        sts_in_t  item;
        bit       has_known;
        sts_out_t known;
    } stim_row_t;

    logic     aclk            = 1'b0;
    logic     aresetn         = 1'b0;
    logic     s_valid         = 1'b0;
    logic     s_ready;
    sts_in_t  s_data          = '0;
    logic     m_valid;
    logic     m_ready         = 1'b0;
    sts_out_t m_data;
    logic     cfg_valid       = 1'b0;
    logic     cfg_ready;
    logic     cfg_search_mode = MODE_BINARY;

    // Predicted copy of the block's state.
    logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
    int   fill_count       = 0;
    bit   order_kept       = 1'b1;
    logic signed [VALUE_W-1:0] last_appended = '0;
    logic search_mode_copy = MODE_BINARY;

    // Results still owed by the block, oldest first.
    sts_out_t pending_outcomes [$];

    int   error_count   = 0;
    int   counted_items = 0;
    int   quiet_cycles  = 0;
    bit   quiet_tail    = 1'b0;
    bit   hold_request  = 1'b0;

    sorted_table_search #(
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_search_mode(cfg_search_mode)
    );

    // The clock period is 4 ns.
    always #2 aclk = ~aclk;

    // Applies one input transaction to the predicted state and returns the result that
    // the block should produce for it.
    function automatic sts_out_t predict_outcome(sts_in_t item);
        sts_out_t                  outcome;
        logic signed [VALUE_W-1:0] key;
        int                        lo;
        int                        hi;
        int                        mid;
        outcome = '0;
        key     = item.value;
        case (item.operation)
            OP_CLEAR: begin
                // The stored elements stay; only the count and the order flag restart.
                fill_count = 0;
                order_kept = 1'b1;
            end
            OP_APPEND: begin
                if (fill_count >= TABLE_DEPTH) begin
                    outcome.full_error = 1'b1;
                end else begin
                    if (fill_count > 0 && last_appended > key) begin
                        order_kept = 1'b0;
                    end
                    table_copy[fill_count] = key;
                    last_appended          = key;
                    fill_count++;
                end
            end
            OP_SEARCH: begin
                if (search_mode_copy == MODE_BINARY) begin
                    // The halving search runs even on an unordered table, and it reports
                    // the first match it lands on, not necessarily the lowest index.
                    lo = 0;
                    hi = fill_count - 1;
                    while (lo <= hi && !outcome.found) begin
                        mid = (lo + hi) / 2;
                        if (table_copy[mid] == key) begin
                            outcome.found    = 1'b1;
                            outcome.position = mid[POS_W-1:0];
                        end else if (table_copy[mid] > key) begin
                            hi = mid - 1;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                end else begin
                    for (int i = 0; i < fill_count && !outcome.found; i++) begin
                        if (table_copy[i] == key) begin
                            outcome.found    = 1'b1;
                            outcome.position = i[POS_W-1:0];
                        end
                    end
                end
            end
            default: begin
                // The unused code leaves the state alone.
            end
        endcase
        outcome.in_order = order_kept;
        return outcome;
    endfunction

    function automatic int pick_value(value_spread_t spread);
        case (spread)
            SPREAD_NARROW: return int'($urandom_range(0, 16)) - 8;
            SPREAD_MID:    return int'($urandom_range(0, 2000)) - 1000;
            SPREAD_FULL:   return int'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MIN + 1;
                    2:       return VALUE_MAX;
                    3:       return VALUE_MAX - 1;
                    4:       return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic stim_row_t item_row(sts_op_t op, int value);
        stim_row_t row;
        row               = '{default: '0};
        row.item.operation = op;
        row.item.value     = value;
        return row;
    endfunction

    function automatic stim_row_t known_row(sts_op_t op, int value, bit found,
                                            logic [POS_W-1:0] position, bit in_order,
                                            bit full_error);
        stim_row_t row;
        row           = item_row(op, value);
        row.has_known = 1'b1;
        row.known     = '{found: found, position: position, in_order: in_order,
                          full_error: full_error};
        return row;
    endfunction

    function automatic stim_row_t mode_row(logic mode);
        stim_row_t row;
        row               = '{default: '0};
        row.is_mode_write = 1'b1;
        row.mode_value    = mode;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        end
    endtask

    // Offers one input transaction and holds it until the block takes it. The task is
    // entered right after a rising edge, so every drive here is a nonblocking assignment
    // at an edge, and valid is only ever raised, never lowered and raised in one step.
    task automatic send_item(sts_in_t item, bit has_known = 1'b0, sts_out_t known = '0);
        sts_out_t predicted;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // The transaction was taken at this edge; the predictor advances with it.
        predicted = predict_outcome(item);
        pending_outcomes.push_back(has_known ? known : predicted);
        if (item.operation != OP_UNUSED) begin
            counted_items++;
        end
    endtask

    // Lowers valid and waits until every owed result has come back, so the block is idle.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_search_mode(logic mode);
        wait_until_drained();
        cfg_valid       <= 1'b1;
        cfg_search_mode <= mode;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid        <= 1'b0;
        search_mode_copy  = mode;
    endtask

    // Stimulus: reset, the directed table, then random phases. Each random phase mostly
    // clears the table, fills it with a sorted run of values and searches it, since that
    // is where the two search modes differ; unordered fills, stray appends, clears and
    // the unused code make up the rest.
    initial begin : stimulus
        stim_row_t     rows [$];
        int            phase_values [$];
        int            fill_len;
        int            search_len;
        int            phase_index;
        int            key;
        value_spread_t spread;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Binary mode is the reset value of the register.
        rows.push_back(known_row(OP_SEARCH, 0, 0, 0, 1, 0));   // Search of an empty table.
        rows.push_back(known_row(sts_op_t'(OP_UNUSED), 0, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, VALUE_MIN, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, -1, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, 0, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, 0, 0, 0, 1, 0));   // Equal neighbors keep order.
        rows.push_back(known_row(OP_APPEND, VALUE_MAX, 0, 0, 1, 0));
        rows.push_back(item_row(OP_SEARCH, VALUE_MIN));
        rows.push_back(item_row(OP_SEARCH, VALUE_MAX));
        rows.push_back(item_row(OP_SEARCH, 0));
        rows.push_back(known_row(OP_SEARCH, 5, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, -5, 0, 0, 0, 0));  // Breaks the order.
        rows.push_back(item_row(OP_SEARCH, -5));               // Halving an unordered table.
        rows.push_back(known_row(sts_op_t'(OP_UNUSED), -1, 0, 0, 0, 0));
        rows.push_back(known_row(OP_CLEAR, -1, 0, 0, 1, 0));
        rows.push_back(known_row(OP_SEARCH, -1, 0, 0, 1, 0));  // Old elements are not visible.
        rows.push_back(mode_row(MODE_LINEAR));
        rows.push_back(known_row(OP_APPEND, 7, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, 3, 0, 0, 0, 0));
        rows.push_back(known_row(OP_APPEND, 7, 0, 0, 0, 0));
        rows.push_back(item_row(OP_SEARCH, 7));                // Lowest of two matches.
        rows.push_back(item_row(OP_SEARCH, 3));
        rows.push_back(known_row(OP_SEARCH, 9, 0, 0, 0, 0));
        rows.push_back(known_row(OP_CLEAR, 0, 0, 0, 1, 0));
        rows.push_back(known_row(OP_APPEND, VALUE_MAX, 0, 0, 1, 0));
        rows.push_back(item_row(OP_SEARCH, VALUE_MAX));
        rows.push_back(mode_row(MODE_BINARY));

        foreach (rows[i]) begin
            if (rows[i].is_mode_write) begin
                write_search_mode(rows[i].mode_value);
            end else begin
                send_item(rows[i].item, rows[i].has_known, rows[i].known);
            end
        end

        phase_index = 0;
        while (counted_items < TOTAL_ITEMS) begin
            phase_index++;
            if (phase_index == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            if (counted_items >= QUIET_AFTER) begin
                quiet_tail = 1'b1;
            end
            if ($urandom_range(0, 1) == 0) begin
                write_search_mode(1'($urandom_range(0, 1)));
            end

            spread = value_spread_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       fill_len = 0;
                1:       fill_len = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6); // Fills the table; may overflow.
                2:       fill_len = $urandom_range(16, 40);
                default: fill_len = $urandom_range(1, 12);
            endcase
            phase_values.delete();
            for (int k = 0; k < fill_len; k++) begin
                phase_values.push_back(pick_value(spread));
            end
            if ($urandom_range(0, 4) != 0) begin
                phase_values.sort();
            end

            // Now and then the phase builds on whatever the table already holds.
            if ($urandom_range(0, 9) != 0) begin
                send_item('{operation: OP_CLEAR, value: $urandom});
            end
            foreach (phase_values[k]) begin
                send_item('{operation: OP_APPEND, value: phase_values[k]});
            end

            search_len = $urandom_range(2, 10);
            for (int k = 0; k < search_len; k++) begin
                case ($urandom_range(0, 19))
                    0: send_item('{operation: sts_op_t'(OP_UNUSED), value: $urandom});
                    1: send_item('{operation: OP_APPEND, value: pick_value(spread)});
                    2: send_item('{operation: OP_CLEAR, value: $urandom});
                    default: begin
                        if (phase_values.size() == 0 || $urandom_range(0, 9) < 2) begin
                            key = pick_value(spread);
                        end else begin
                            key = phase_values[$urandom_range(0, phase_values.size() - 1)];
                            // Neighbors of stored values probe the misses between hits.
                            if ($urandom_range(0, 9) < 3) begin
                                key = ($urandom_range(0, 1) == 0) ? key + 1 : key - 1;
                            end
                        end
                        send_item('{operation: OP_SEARCH, value: key});
                    end
                endcase
            end
        end

        // All stimulus is in. Collect the remaining results, then watch a little longer for
        // anything spurious before the verdict.
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result receiver. It is mostly ready, with random stall bursts, and once
    // holds off for a long stretch so that the output register fills and the block stops
    // taking input transactions. In the last part of the run it never stalls.
    initial begin : result_receiver
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Compares each result transaction with the oldest owed result, field by field.
    always @(posedge aclk) begin : result_check
        sts_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_data), 32'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_data.found !== want.found) begin
                    report_mismatch("found", 32'(m_data.found), 32'(want.found));
                end
                if (m_data.position !== want.position) begin
                    report_mismatch("position", 32'(m_data.position), 32'(want.position));
                end
                if (m_data.in_order !== want.in_order) begin
                    report_mismatch("in_order", 32'(m_data.in_order), 32'(want.in_order));
                end
                if (m_data.full_error !== want.full_error) begin
                    report_mismatch("full_error", 32'(m_data.full_error),
                                    32'(want.full_error));
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction of any kind completes for too long. The
    // slowest correct gap is the long receiver hold, well below the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
